// ----- hw/rtl/rmed_pkg.sv -----
`timescale 1ns / 1ps
// rmed_pkg: shared types and constants for the running median core
// no dependencies

package rmed_pkg;

  localparam int SAMPLE_BITS  = 16;
  localparam int MEDIAN_BITS  = SAMPLE_BITS + 1;
  localparam int COUNT_BITS   = 9;
  localparam int DEF_CAPACITY = 256;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          first;
  } rmed_in_t;

  typedef struct packed {
    logic signed [MEDIAN_BITS-1:0] median_x2;
    logic [COUNT_BITS-1:0]         sample_count;
    logic                          full_res;
  } rmed_out_t;

  typedef struct packed {
    logic                          ins;
    logic signed [SAMPLE_BITS-1:0] sample;
  } rmed_cell_ctl_t;

  // registered levels of a fan-in-4 reduction over n leaves
  function automatic int tree_levels(input int n);
    int lv;
    lv = ($clog2(n) + 1) / 2;
    if (lv < 1) begin
      lv = 1;
    end
    return lv;
  endfunction

endpackage

// ----- hw/rtl/rmed_cell.sv -----
`timescale 1ns / 1ps
// rmed_cell: one slot of the sorted sample chain
// depends on rmed_pkg

module rmed_cell #(
  parameter int IDX = 0,
  parameter int CW  = 9
) (
  input  logic                                   clk,
  input  rmed_pkg::rmed_cell_ctl_t               ctl_i,
  input  logic [CW-1:0]                          eff_cnt_i,
  input  logic [CW-1:0]                          idx_lo_i,
  input  logic [CW-1:0]                          idx_hi_i,
  input  logic signed [rmed_pkg::SAMPLE_BITS-1:0] prev_v_i,
  input  logic                                   prev_gt_i,
  output logic signed [rmed_pkg::SAMPLE_BITS-1:0] v_o,
  output logic                                   gt_o,
  output logic [2*rmed_pkg::SAMPLE_BITS-1:0]     sel_o
);
  import rmed_pkg::*;

  localparam logic [CW-1:0] MY_IDX = CW'(IDX);

  logic signed [SAMPLE_BITS-1:0] v_r;
  logic [2*SAMPLE_BITS-1:0]      sel_r;
  logic                          valid;
  logic                          gt;

  assign valid = MY_IDX < eff_cnt_i;
  assign gt    = valid && (v_r > ctl_i.sample);

  // shift right past larger neighbors, or take the new sample at the boundary
  always_ff @(posedge clk) begin
    if (ctl_i.ins) begin
      if (prev_gt_i) begin
        v_r <= prev_v_i;
      end else if (gt || (MY_IDX == eff_cnt_i)) begin
        v_r <= ctl_i.sample;
      end
    end
  end

  always_ff @(posedge clk) begin
    sel_r[2*SAMPLE_BITS-1:SAMPLE_BITS] <= (MY_IDX == idx_lo_i) ? v_r : '0;
    sel_r[SAMPLE_BITS-1:0]             <= (MY_IDX == idx_hi_i) ? v_r : '0;
  end

  assign v_o   = v_r;
  assign gt_o  = gt;
  assign sel_o = sel_r;

endmodule

// ----- hw/rtl/rmed_or_tree.sv -----
`timescale 1ns / 1ps
// rmed_or_tree: registered fan-in-4 or reduction of the cell selections
// depends on rmed_pkg

module rmed_or_tree #(
  parameter int N = 256,
  parameter int W = 32
) (
  input  logic         clk,
  input  logic [W-1:0] leaf_i [N],
  output logic [W-1:0] root_o
);
  import rmed_pkg::*;

  localparam int LEVELS = tree_levels(N);
  localparam int NLEAF  = 4 ** LEVELS;
  localparam int NTOP   = NLEAF / 4;

  logic [W-1:0] lvl0 [NLEAF];
  logic [W-1:0] node_r [LEVELS][NTOP];

  for (genvar i = 0; i < NLEAF; i++) begin : g_pad
    if (i < N) begin : g_real
      assign lvl0[i] = leaf_i[i];
    end else begin : g_zero
      assign lvl0[i] = '0;
    end
  end

  for (genvar l = 0; l < LEVELS; l++) begin : g_lvl
    localparam int CNT = NLEAF >> (2 * (l + 1));
    for (genvar j = 0; j < NTOP; j++) begin : g_node
      if (j >= CNT) begin : g_unused
        always_ff @(posedge clk) begin
          node_r[l][j] <= '0;
        end
      end else if (l == 0) begin : g_first
        always_ff @(posedge clk) begin
          node_r[l][j] <= lvl0[4*j] | lvl0[4*j+1] | lvl0[4*j+2] | lvl0[4*j+3];
        end
      end else begin : g_upper
        always_ff @(posedge clk) begin
          node_r[l][j] <= node_r[l-1][4*j] | node_r[l-1][4*j+1]
                        | node_r[l-1][4*j+2] | node_r[l-1][4*j+3];
        end
      end
    end
  end

  assign root_o = node_r[LEVELS-1][0];

endmodule

// ----- hw/rtl/running_median_core.sv -----
`timescale 1ns / 1ps
// running_median_core: running median of a signed sample stream, result doubled
// depends on rmed_pkg, rmed_cell, rmed_or_tree
//
// usage:
//   in_valid/in_ready/in_data carry one sample per transaction; in_data.first
//   starts a new sequence and discards all held samples before this one.
//   out_valid/out_ready/out_data carry one result per input transaction:
//   twice the median (or the sum of the two middle values), the number of
//   samples held, and full_res when the sample was dropped on a full store.
//   samples sit in a chain of CAPACITY cells kept in ascending order; an
//   insert shifts all the larger cells one place on the edge that takes it.
//   the two middle cells are picked out by a registered fan-in-4 or tree of
//   L = ceil(log2(CAPACITY)/2) levels (L = 4 for 256 entries).
//   a sample passes through the registered cell selections, the L tree
//   levels and the output register; in_ready stays low while any sample is
//   in flight, so a new sample is taken only once the last has left the tree.
//   a finished result waits in the output register while the next sample is
//   taken; a second finished result waits in one holding register, and input
//   stops until it moves on.
//   reset (rst_n low, synchronous) empties the store and drops any result in
//   flight; in_ready is held low; cell contents are not cleared.

module running_median_core #(
  parameter int CAPACITY = rmed_pkg::DEF_CAPACITY
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  rmed_pkg::rmed_in_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output rmed_pkg::rmed_out_t out_data
);
  import rmed_pkg::*;

  localparam int CW     = $clog2(CAPACITY + 1);
  localparam int LEVELS = tree_levels(CAPACITY);
  localparam int PD     = LEVELS + 2;
  localparam int SW     = 2 * SAMPLE_BITS;

  logic [CW-1:0]    count_r, count_nxt;
  logic             full_r;
  logic [PD-1:0]    pipe_r;
  logic             out_valid_r, pend_valid_r;
  rmed_out_t        out_r, pend_r, res;

  logic             accept, drop, done, out_free;
  logic [CW-1:0]    eff_cnt, idx_lo, idx_hi;
  rmed_cell_ctl_t   ctl;

  logic signed [SAMPLE_BITS-1:0] cell_v  [CAPACITY];
  logic                          cell_gt [CAPACITY];
  logic [SW-1:0]                 cell_sel [CAPACITY];
  logic [SW-1:0]                 root;
  logic signed [SAMPLE_BITS-1:0] mid_lo, mid_hi;

  assign in_ready = rst_n && ~(|pipe_r) && !pend_valid_r;
  assign accept   = in_valid && in_ready;
  assign eff_cnt  = in_data.first ? '0 : count_r;
  assign drop     = eff_cnt == CW'(CAPACITY);
  assign count_nxt = drop ? eff_cnt : eff_cnt + CW'(1);

  assign ctl.ins    = accept && !drop;
  assign ctl.sample = in_data.sample;

  assign idx_hi = count_r >> 1;
  assign idx_lo = (count_r - CW'(1)) >> 1;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [SAMPLE_BITS-1:0] pv;
    logic                          pg;
    if (i == 0) begin : g_head
      assign pv = '0;
      assign pg = 1'b0;
    end else begin : g_body
      assign pv = cell_v[i-1];
      assign pg = cell_gt[i-1];
    end
    rmed_cell #(
      .IDX (i),
      .CW  (CW)
    ) u_cell (
      .clk       (clk),
      .ctl_i     (ctl),
      .eff_cnt_i (eff_cnt),
      .idx_lo_i  (idx_lo),
      .idx_hi_i  (idx_hi),
      .prev_v_i  (pv),
      .prev_gt_i (pg),
      .v_o       (cell_v[i]),
      .gt_o      (cell_gt[i]),
      .sel_o     (cell_sel[i])
    );
  end

  rmed_or_tree #(
    .N (CAPACITY),
    .W (SW)
  ) u_tree (
    .clk    (clk),
    .leaf_i (cell_sel),
    .root_o (root)
  );

  assign mid_lo = root[SW-1:SAMPLE_BITS];
  assign mid_hi = root[SAMPLE_BITS-1:0];

  assign res.median_x2    = MEDIAN_BITS'(mid_lo) + MEDIAN_BITS'(mid_hi);
  assign res.sample_count = COUNT_BITS'(count_r);
  assign res.full_res     = full_r;

  assign done     = pipe_r[PD-1];
  assign out_free = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      pipe_r  <= '0;
    end else begin
      pipe_r <= {pipe_r[PD-2:0], accept};
      if (accept) begin
        count_r <= count_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      full_r <= drop;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      pend_valid_r <= 1'b0;
    end else begin
      priority if (done) begin
        if (out_free) begin
          out_r       <= res;
          out_valid_r <= 1'b1;
        end else begin
          pend_r       <= res;
          pend_valid_r <= 1'b1;
        end
      end else if (pend_valid_r && out_free) begin
        out_r        <= pend_r;
        out_valid_r  <= 1'b1;
        pend_valid_r <= 1'b0;
      end else if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

// ----- hw/rtl/rmed_checker.sv -----
`timescale 1ns / 1ps
// rmed_checker: port-level checks for running_median_core, bound to the top level
// depends on rmed_pkg, running_median_core

module rmed_checker #(
  parameter int CAPACITY = rmed_pkg::DEF_CAPACITY
) (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input rmed_pkg::rmed_in_t  in_data,
  input logic                out_valid,
  input logic                out_ready,
  input rmed_pkg::rmed_out_t out_data
);
  import rmed_pkg::*;

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // one sample in flight at a time
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second transaction taken while busy");

  // a dropped sample only happens on a full store
  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.full_res |-> out_data.sample_count == COUNT_BITS'(CAPACITY))
    else $error("full flag with store not full");

  // reset empties the output
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result survived reset");

  // a fresh sequence never reports a drop
  a_first_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.sample_count == COUNT_BITS'(1) |-> !out_data.full_res ||
      COUNT_BITS'(CAPACITY) == COUNT_BITS'(1))
    else $error("drop reported with a single sample held");

endmodule

bind running_median_core rmed_checker #(.CAPACITY(CAPACITY)) u_rmed_checker (.*);

// ----- verif/tb.sv -----
`timescale 1ns / 1ps
// tb: self-checking bench for running_median_core, predicts each doubled median
// from its own sorted copy of the held samples; depends on rmed_pkg and the core

module tb;
  import rmed_pkg::*;

  localparam int CAPACITY    = DEF_CAPACITY;
  localparam int MAX_REPORTS = 10;

  class median_scoreboard;
    logic signed [SAMPLE_BITS-1:0] sorted_samples [CAPACITY];
    int unsigned held;
    rmed_out_t   expected_q[$];
    int          mismatches;
    int          accepted;
    int          checked;
    int          dropped;

    function new();
      held       = 0;
      mismatches = 0;
      accepted   = 0;
      checked    = 0;
      dropped    = 0;
    endfunction

    // insert the sample in ascending order and queue the expected transaction
    function void note_sample(rmed_in_t t);
      rmed_out_t                     r;
      logic signed [SAMPLE_BITS-1:0] x;
      logic signed [MEDIAN_BITS-1:0] lo;
      logic signed [MEDIAN_BITS-1:0] hi;
      int unsigned                   pos;
      int unsigned                   mid;
      x = t.sample;
      r = '0;
      accepted++;
      if (t.first) begin
        held = 0;
      end
      if (held < CAPACITY) begin
        pos = held;
        while (pos > 0 && sorted_samples[pos-1] > x) begin
          sorted_samples[pos] = sorted_samples[pos-1];
          pos--;
        end
        sorted_samples[pos] = x;
        held++;
      end else begin
        r.full_res = 1'b1;
        dropped++;
      end
      mid = held / 2;
      hi  = sorted_samples[mid];
      lo  = held[0] ? sorted_samples[mid] : sorted_samples[mid-1];
      r.median_x2    = lo + hi;
      r.sample_count = held[COUNT_BITS-1:0];
      expected_q = {expected_q, r};
    endfunction

    function void report(string what, rmed_out_t exp, rmed_out_t got);
      mismatches++;
      if (mismatches <= MAX_REPORTS) begin
        $display("mismatch %0d (%s): expected x2=%0d cnt=%0d full=%0d, got x2=%0d cnt=%0d full=%0d",
                 mismatches, what, exp.median_x2, exp.sample_count, exp.full_res,
                 got.median_x2, got.sample_count, got.full_res);
      end
    endfunction

    function void check_result(rmed_out_t got);
      rmed_out_t exp;
      if (expected_q.size() == 0) begin
        report("nothing pending", '0, got);
      end else begin
        exp = expected_q.pop_front();
        checked++;
        if (got.median_x2 !== exp.median_x2 || got.sample_count !== exp.sample_count ||
            got.full_res !== exp.full_res) begin
          report("field", exp, got);
        end
      end
    endfunction
  endclass

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  rmed_in_t  in_data;
  logic      out_valid;
  logic      out_ready;
  rmed_out_t out_data;

  int in_idle_pct;
  int out_stall_pct;

  median_scoreboard sb;

  running_median_core #(
    .CAPACITY(CAPACITY)
  ) u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  initial begin
    clk = 1'b0;
  end

  always #4 clk = ~clk;

  // result side: random stalls set at the falling edge
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      out_ready = ($urandom_range(99) >= out_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      sb.check_result(out_data);
    end
  end

  task automatic send_sample(input logic signed [SAMPLE_BITS-1:0] s, input logic f);
    rmed_in_t t;
    t.sample = s;
    t.first  = f;
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_data  = t;
    in_valid = 1'b1;
    do @(posedge clk); while (!in_ready);
    sb.note_sample(t);
    @(negedge clk);
  endtask

  // mostly full-range values, some narrow ones for ties, some extremes
  function automatic logic signed [SAMPLE_BITS-1:0] pick_sample();
    int r;
    r = $urandom_range(9);
    if (r < 6) begin
      return SAMPLE_BITS'($urandom_range(65535));
    end else if (r < 8) begin
      return SAMPLE_BITS'(int'($urandom_range(8)) - 4);
    end
    case ($urandom_range(3))
      0:       return 16'sh8000;
      1:       return 16'sh7fff;
      2:       return -16'sd1;
      default: return 16'sd0;
    endcase
  endfunction

  task automatic run_sequence(input int len, input bit fresh);
    for (int j = 0; j < len; j++) begin
      send_sample(pick_sample(), (j == 0) && fresh);
    end
  endtask

  initial begin
    int budget;
    int len;
    sb            = new();
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_data       = '0;
    in_idle_pct   = 0;
    out_stall_pct = 0;
    repeat (7) @(negedge clk);
    rst_n = 1'b1;

    // empty store without a start flag, extremes, ties, restarts
    send_sample(16'sh7fff, 1'b0);
    send_sample(16'sh8000, 1'b0);
    send_sample(16'sh8000, 1'b0);
    send_sample(16'sh7fff, 1'b1);
    send_sample(16'sh7fff, 1'b0);
    send_sample(16'sd0, 1'b0);
    send_sample(16'sd0, 1'b0);
    send_sample(16'sd0, 1'b0);
    send_sample(-16'sd1, 1'b0);
    send_sample(16'sd1, 1'b0);
    send_sample(16'sd1, 1'b1);
    send_sample(-16'sd1, 1'b0);
    send_sample(16'sd0, 1'b0);
    send_sample(16'sd16384, 1'b0);
    send_sample(-16'sd16384, 1'b0);
    send_sample(16'sd21845, 1'b0);
    send_sample(-16'sd21846, 1'b0);
    send_sample(16'sh8000, 1'b1);

    for (int p = 0; p < 4; p++) begin
      case (p)
        0: begin
          in_idle_pct   = 0;
          out_stall_pct = 0;
        end
        1: begin
          in_idle_pct   = 60;
          out_stall_pct = 0;
        end
        2: begin
          in_idle_pct   = 0;
          out_stall_pct = 60;
        end
        default: begin
          in_idle_pct   = 7;
          out_stall_pct = 7;
        end
      endcase
      if (p == 0) begin
        // fill the store past capacity so samples get dropped
        run_sequence($urandom_range(CAPACITY + 2, CAPACITY + 8), 1'b1);
      end else begin
        budget = 0;
        while (budget < 115) begin
          len = $urandom_range(1, 24);
          run_sequence(len, (budget == 0) || ($urandom_range(9) != 0));
          budget += len;
        end
      end
    end
    in_valid = 1'b0;

    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);

    $display("%0d samples sent across four idle/stall phases, %0d results checked",
             sb.accepted, sb.checked);
    $display("%0d samples dropped on a full store, %0d mismatches, %0d results missing",
             sb.dropped, sb.mismatches, sb.expected_q.size());
    if (sb.mismatches == 0 && sb.expected_q.size() == 0) begin
      $display("running_median_core regression: pass");
    end else begin
      $display("running_median_core regression: fail");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("timeout with %0d results outstanding", sb.expected_q.size());
    $display("running_median_core regression: fail");
    $finish;
  end

endmodule

// ----- running_median_core.f -----
hw/rtl/rmed_pkg.sv
hw/rtl/rmed_cell.sv
hw/rtl/rmed_or_tree.sv
hw/rtl/running_median_core.sv
hw/rtl/rmed_checker.sv
verif/tb.sv
